[src/cppl_pkg.sv]
// Package of the C++ token lexer: token kinds, lexer modes, keyword table
// and the token record passed between the lexer stages. No dependencies.
package cppl_pkg;

  localparam int unsigned KEYWORD_MAX_LEN = 16;
  localparam int unsigned KW_TEXT_MAX     = 16;
  localparam int unsigned KW_NUM          = 31;
  localparam int unsigned KW_TRUE_IDX     = 28;
  localparam int unsigned QDEPTH          = 4;
  localparam logic [15:0] LINE_MAX        = 16'hFFFF;
  localparam logic [11:0] COL_MAX         = 12'hFFF;

  typedef enum logic [6:0] {
    K_SCOPE_RES, K_COLON, K_PTR_TO_MEMB, K_MEMB_SEL, K_MUL_ASSIGN, K_MUL,
    K_DIV_ASSIGN, K_DIV, K_MOD_ASSIGN, K_MOD, K_ADD_ASSIGN, K_INC, K_ADD,
    K_PTR_PTR_MEMB, K_PTR_MEMB, K_SUB_ASSIGN, K_DEC, K_SUB, K_SHL_ASSIGN,
    K_SHL, K_LTEQ, K_LT, K_SHR_ASSIGN, K_SHR, K_GTEQ, K_GT, K_EQ, K_ASSIGN,
    K_NEQ, K_LNOT, K_LAND, K_AND_ASSIGN, K_BAND, K_XOR_ASSIGN, K_BXOR, K_LOR,
    K_OR_ASSIGN, K_BOR, K_COMMA, K_BNOT, K_LPAREN, K_RPAREN, K_LSQ, K_RSQ,
    K_LCURLY, K_RCURLY, K_SEMI,
    K_CHAR, K_WCHAR, K_CHAR16, K_CHAR32, K_BOOL, K_INT, K_FLOAT, K_DOUBLE,
    K_CLASS, K_STRUCT, K_UNION, K_ENUM, K_SHORT, K_LONG, K_SIGNED,
    K_UNSIGNED, K_STATIC, K_CONSTEXPR, K_TYPEDEF, K_CONST, K_TYPEID,
    K_CONSTCAST, K_DYNAMICCAST, K_REINTERPRETCAST, K_STATICCAST, K_NEW,
    K_DELETE, K_THROW,
    K_BOOL_LIT, K_PTR_LIT, K_INT_LIT, K_UINT_LIT, K_LONG_LIT, K_ULONG_LIT,
    K_LONGLONG_LIT, K_ULONGLONG_LIT, K_FLOAT_LIT, K_DOUBLE_LIT,
    K_LONGDOUBLE_LIT, K_IDENT, K_END, K_UNKNOWN
  } kind_e;

  typedef enum logic [22:0] {
    M_IDLE  = 23'd1 << 0,  M_COLON = 23'd1 << 1,  M_DOT   = 23'd1 << 2,
    M_STAR  = 23'd1 << 3,  M_SLASH = 23'd1 << 4,  M_PCT   = 23'd1 << 5,
    M_PLUS  = 23'd1 << 6,  M_MINUS = 23'd1 << 7,  M_ARROW = 23'd1 << 8,
    M_LT    = 23'd1 << 9,  M_LT2   = 23'd1 << 10, M_GT    = 23'd1 << 11,
    M_GT2   = 23'd1 << 12, M_EQ    = 23'd1 << 13, M_BANG  = 23'd1 << 14,
    M_AMP   = 23'd1 << 15, M_CARET = 23'd1 << 16, M_BAR   = 23'd1 << 17,
    M_IDENT = 23'd1 << 18, M_NUM   = 23'd1 << 19, M_SUF_U = 23'd1 << 20,
    M_SUF_UL = 23'd1 << 21, M_SUF_L = 23'd1 << 22
  } mode_e;

  typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX, RADIX_BIN} radix_e;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] line;
    logic [11:0] column;
    logic [63:0] value;
    logic [7:0]  len;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic v0;
    tok_t tok0;
    logic v1;
    tok_t tok1;
  } push_t;

  localparam logic [8*KW_TEXT_MAX-1:0] KW_TXT [KW_NUM] = '{
    "char", "wchar_t", {"char16", "_t"}, {"char32", "_t"}, "bool", "int", "float",
    "double", "class", "struct", "union", "enum", "short", "long", "signed",
    "unsigned", "static", "constexpr", "typedef", "const", "typeid",
    {"const", "_cast"}, {"dynamic", "_cast"}, {"reinterpret", "_cast"},
    {"static", "_cast"}, "new", "delete", "throw", "true", "false", "nullptr"};

  localparam int unsigned KW_LEN [KW_NUM] = '{
    4, 7, 8, 8, 4, 3, 5, 6, 5, 6, 5, 4, 5, 4, 6, 8, 6, 9, 7, 5, 6, 10, 12,
    16, 11, 3, 6, 5, 4, 5, 7};

  localparam kind_e KW_KIND [KW_NUM] = '{
    K_CHAR, K_WCHAR, K_CHAR16, K_CHAR32, K_BOOL, K_INT, K_FLOAT, K_DOUBLE,
    K_CLASS, K_STRUCT, K_UNION, K_ENUM, K_SHORT, K_LONG, K_SIGNED,
    K_UNSIGNED, K_STATIC, K_CONSTEXPR, K_TYPEDEF, K_CONST, K_TYPEID,
    K_CONSTCAST, K_DYNAMICCAST, K_REINTERPRETCAST, K_STATICCAST, K_NEW,
    K_DELETE, K_THROW, K_BOOL_LIT, K_BOOL_LIT, K_PTR_LIT};

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hexletter(input logic [7:0] c);
    return ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
  endfunction

  // Result is {hit, kind, literal bit}; the first table entry that matches wins.
  function automatic logic [8:0] kw_match(input logic [KW_TEXT_MAX-1:0][7:0] txt,
                                          input logic [7:0] cnt);
    logic [8:0] res;
    logic       eq;
    res = '0;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      eq = (cnt == 8'(KW_LEN[k]));
      for (int i = 0; i < KW_TEXT_MAX; i++) begin
        if ((i < KW_LEN[k]) && (txt[i] != KW_TXT[k][(KW_LEN[k] - 1 - i) * 8 +: 8])) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        res = {1'b1, 7'(KW_KIND[k]), k == KW_TRUE_IDX};
      end
    end
    return res;
  endfunction

endpackage

[src/cppl_if.sv]
// Handshake interfaces of the C++ token lexer: the byte channel and the
// token channel. Depends on nothing.
interface cppl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface cppl_token_if;
  logic        valid;
  logic        ready;
  logic [6:0]  token_kind;
  logic [15:0] token_line;
  logic [11:0] token_column;
  logic [63:0] lit_value;
  logic [7:0]  ident_length;
  logic        last_of_run;
  modport source (output valid, output token_kind, output token_line,
                  output token_column, output lit_value, output ident_length,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_line,
                input token_column, input lit_value, input ident_length,
                input last_of_run, output ready);
endinterface

[src/cpp_token_lexer_unit.sv]
// Top level of the C++ token lexer: front end, token queue and output stage.
// Depends on cppl_pkg, cppl_if, cppl_front, cppl_queue and cppl_back.
//
// The text channel takes one source byte per item; byte 0 ends the text and
// yields the end token, after which line and column restart at 1.
// The token channel gives one token per item with its kind, start line and
// column, integer or bool value, identifier length and a flag that marks the
// last token caused by a byte. One byte causes zero, one or two tokens.
// A token is often caused by the byte that follows it, since operators,
// numbers and identifiers close on lookahead.
// Throughput is one byte per cycle while the four-entry token queue has room
// for two tokens. A token caused by an accepted byte passes through the token
// queue and then the output register before it shows on the token channel.
// When the receiver stalls, the output register holds its token, the queue
// fills and text ready drops until space frees up.
// Reset empties the queue and returns the lexer to its idle mode at line 1,
// column 1.
module cpp_token_lexer_unit #(
  parameter int unsigned KeywordMaxLen = cppl_pkg::KEYWORD_MAX_LEN
) (
  input logic          clk_i,
  input logic          rst_ni,
  cppl_byte_if.sink    text_i,
  cppl_token_if.source token_o
);
  import cppl_pkg::*;

  push_t push;
  tok_t  head;
  logic  room, head_valid, pop;

  cppl_front #(.KeywordMaxLen(KeywordMaxLen)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_i),
    .room_i (room),
    .push_o (push)
  );

  cppl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  cppl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .token_o      (token_o)
  );

endmodule

[src/cppl_front.sv]
// Lexer front end: takes one byte per cycle while there is room, runs the
// lexer state machine and pushes up to two tokens. Depends on cppl_pkg and cppl_byte_if.
module cppl_front #(
  parameter int unsigned KeywordMaxLen = cppl_pkg::KEYWORD_MAX_LEN
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cppl_byte_if.sink       text_i,
  input  logic            room_i,
  output cppl_pkg::push_t push_o
);
  import cppl_pkg::*;

  localparam int unsigned IdxW = $clog2(KeywordMaxLen);

  mode_e       mode_q, mode_d;
  logic [1:0]  pc_q, pc_d;
  logic [63:0] acc_q, acc_d;
  logic        dec_q, dec_d, stop_q, stop_d;
  radix_e      rad_q, rad_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] line_q, line_d, sline_q, sline_d;
  logic [11:0] col_q, col_d, scol_q, scol_d;
  logic [7:0]  idbuf_q [KeywordMaxLen];

  logic [KW_TEXT_MAX-1:0][7:0] kw_view;
  logic [8:0]  kw_res;
  logic [7:0]  b, lb;
  logic        acc;
  logic        cons, do_pair, nb_en, num_emit, valid_ch, ell;
  logic [7:0]  pr;
  kind_e       num_kind;
  logic [1:0]  n_pc;
  logic        n_dec, n_stop;
  radix_e      n_rad;
  logic [63:0] n_acc;
  logic        p_v, i_v;
  kind_e       p_kind, i_kind;
  logic [63:0] p_val;
  logic [7:0]  p_len;
  logic        wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [6:0]  dv;
  logic [4:0]  rv;
  logic [67:0] prod;

  function automatic logic [7:0] pair_f(input logic [7:0] c, input logic [7:0] c1,
                                        input kind_e k1, input logic [7:0] c2,
                                        input kind_e k2, input kind_e base);
    logic [7:0] r;
    if (c == c1) begin
      r = {1'b1, 7'(k1)};
    end else if ((c2 != 8'd0) && (c == c2)) begin
      r = {1'b1, 7'(k2)};
    end else begin
      r = {1'b0, 7'(base)};
    end
    return r;
  endfunction

  assign b   = text_i.text_byte;
  assign lb  = to_lower(b);
  assign ell = (lb == "l");
  assign acc = text_i.valid && room_i;
  assign text_i.ready = room_i;

  always_comb begin
    for (int i = 0; i < KW_TEXT_MAX; i++) begin
      kw_view[i] = idbuf_q[i];
    end
  end
  assign kw_res = kw_match(kw_view, cnt_q);

  always_comb begin
    mode_d = mode_q; pc_d = pc_q; acc_d = acc_q; dec_d = dec_q; stop_d = stop_q;
    rad_d = rad_q; cnt_d = cnt_q; line_d = line_q; col_d = col_q;
    sline_d = sline_q; scol_d = scol_q;
    cons = 1'b0; do_pair = 1'b0; nb_en = 1'b0; num_emit = 1'b0; num_kind = K_INT_LIT;
    pr = '0; valid_ch = 1'b0;
    n_pc = pc_q; n_dec = dec_q; n_stop = stop_q; n_rad = rad_q; n_acc = acc_q;
    p_v = 1'b0; p_kind = K_UNKNOWN; p_val = '0; p_len = '0;
    i_v = 1'b0; i_kind = K_UNKNOWN;
    wr_en = 1'b0; wr_idx = '0;
    dv = 7'd99; rv = 5'd10; prod = '0;

    case (mode_q)
      M_IDLE: begin
      end
      M_COLON: begin
        do_pair = 1'b1; pr = pair_f(b, ":", K_SCOPE_RES, 8'd0, K_UNKNOWN, K_COLON);
      end
      M_DOT: begin
        if (is_digit(b)) begin
          nb_en = 1'b1; n_pc = 2'd1; n_dec = 1'b1; n_stop = 1'b1;
          n_rad = RADIX_DEC; n_acc = '0; mode_d = M_NUM;
        end else begin
          do_pair = 1'b1; pr = pair_f(b, "*", K_PTR_TO_MEMB, 8'd0, K_UNKNOWN, K_MEMB_SEL);
        end
      end
      M_STAR: begin
        do_pair = 1'b1; pr = pair_f(b, "=", K_MUL_ASSIGN, 8'd0, K_UNKNOWN, K_MUL);
      end
      M_SLASH: begin
        do_pair = 1'b1; pr = pair_f(b, "=", K_DIV_ASSIGN, 8'd0, K_UNKNOWN, K_DIV);
      end
      M_PCT: begin
        do_pair = 1'b1; pr = pair_f(b, "=", K_MOD_ASSIGN, 8'd0, K_UNKNOWN, K_MOD);
      end
      M_PLUS: begin
        do_pair = 1'b1; pr = pair_f(b, "=", K_ADD_ASSIGN, "+", K_INC, K_ADD);
      end
      M_MINUS: begin
        if (b == ">") begin
          mode_d = M_ARROW; cons = 1'b1;
        end else begin
          do_pair = 1'b1; pr = pair_f(b, "=", K_SUB_ASSIGN, "-", K_DEC, K_SUB);
        end
      end
      M_ARROW: begin
        do_pair = 1'b1; pr = pair_f(b, "*", K_PTR_PTR_MEMB, 8'd0, K_UNKNOWN, K_PTR_MEMB);
      end
      M_LT: begin
        if (b == "<") begin
          mode_d = M_LT2; cons = 1'b1;
        end else begin
          do_pair = 1'b1; pr = pair_f(b, "=", K_LTEQ, 8'd0, K_UNKNOWN, K_LT);
        end
      end
      M_LT2: begin
        do_pair = 1'b1; pr = pair_f(b, "=", K_SHL_ASSIGN, 8'd0, K_UNKNOWN, K_SHL);
      end
      M_GT: begin
        if (b == ">") begin
          mode_d = M_GT2; cons = 1'b1;
        end else begin
          do_pair = 1'b1; pr = pair_f(b, "=", K_GTEQ, 8'd0, K_UNKNOWN, K_GT);
        end
      end
      M_GT2: begin
        do_pair = 1'b1; pr = pair_f(b, "=", K_SHR_ASSIGN, 8'd0, K_UNKNOWN, K_SHR);
      end
      M_EQ: begin
        do_pair = 1'b1; pr = pair_f(b, "=", K_EQ, 8'd0, K_UNKNOWN, K_ASSIGN);
      end
      M_BANG: begin
        do_pair = 1'b1; pr = pair_f(b, "=", K_NEQ, 8'd0, K_UNKNOWN, K_LNOT);
      end
      M_AMP: begin
        do_pair = 1'b1; pr = pair_f(b, "&", K_LAND, "=", K_AND_ASSIGN, K_BAND);
      end
      M_CARET: begin
        do_pair = 1'b1; pr = pair_f(b, "=", K_XOR_ASSIGN, 8'd0, K_UNKNOWN, K_BXOR);
      end
      M_BAR: begin
        do_pair = 1'b1; pr = pair_f(b, "|", K_LOR, "=", K_OR_ASSIGN, K_BOR);
      end
      M_IDENT: begin
        if (is_alpha(b) || is_digit(b) || (b == "_")) begin
          cons = 1'b1;
          if (cnt_q < 8'(KeywordMaxLen)) begin
            wr_en = 1'b1; wr_idx = cnt_q[IdxW-1:0];
          end
          if (cnt_q != 8'hFF) begin
            cnt_d = cnt_q + 8'd1;
          end
        end else begin
          p_v = 1'b1; mode_d = M_IDLE;
          if (kw_res[8]) begin
            p_kind = kind_e'(kw_res[7:1]); p_val = {63'd0, kw_res[0]};
          end else begin
            p_kind = K_IDENT; p_len = cnt_q;
          end
        end
      end
      M_NUM: nb_en = 1'b1;
      M_SUF_U: begin
        if (ell) begin
          mode_d = M_SUF_UL; cons = 1'b1;
        end else begin
          num_emit = 1'b1; num_kind = K_UINT_LIT;
        end
      end
      M_SUF_UL: begin
        num_emit = 1'b1; num_kind = ell ? K_ULONGLONG_LIT : K_ULONG_LIT; cons = ell;
      end
      M_SUF_L: begin
        num_emit = 1'b1; cons = ell;
        num_kind = ell ? K_LONGLONG_LIT : (dec_q ? K_LONGDOUBLE_LIT : K_LONG_LIT);
      end
      default: mode_d = M_IDLE;
    endcase

    if (do_pair) begin
      p_v = 1'b1; p_kind = kind_e'(pr[6:0]); cons = pr[7]; mode_d = M_IDLE;
    end

    if (is_digit(b)) begin
      dv = 7'(b - "0");
    end else if (is_hexletter(b)) begin
      dv = 7'(lb - "a" + 8'd10);
    end
    case (n_rad)
      RADIX_DEC: begin rv = 5'd10; prod = ({4'd0, n_acc} << 3) + ({4'd0, n_acc} << 1); end
      RADIX_OCT: begin rv = 5'd8;  prod = {4'd0, n_acc} << 3; end
      RADIX_HEX: begin rv = 5'd16; prod = {4'd0, n_acc} << 4; end
      RADIX_BIN: begin rv = 5'd2;  prod = {4'd0, n_acc} << 1; end
      default: begin rv = 5'd10; prod = '0; end
    endcase
    prod = prod + {64'd0, dv[3:0]};

    if (nb_en) begin
      pc_d = n_pc; dec_d = n_dec; stop_d = n_stop; rad_d = n_rad; acc_d = n_acc;
      if ((n_pc == 2'd1) && ((b == "x") || (b == "b"))) begin
        if (n_rad == RADIX_OCT) begin
          rad_d = (b == "x") ? RADIX_HEX : RADIX_BIN;
        end else begin
          stop_d = 1'b1;
        end
        pc_d = 2'd2; cons = 1'b1;
      end else begin
        dec_d = n_dec | (b == ".");
        valid_ch = is_digit(b) || (b == ".") || (!dec_d && is_hexletter(b));
        if (!valid_ch) begin
          case (lb)
            "u": begin mode_d = M_SUF_U; cons = 1'b1; end
            "l": begin mode_d = M_SUF_L; cons = 1'b1; end
            "f": begin num_emit = 1'b1; num_kind = K_FLOAT_LIT; cons = 1'b1; end
            "d": begin num_emit = 1'b1; num_kind = K_DOUBLE_LIT; cons = 1'b1; end
            default: begin num_emit = 1'b1; num_kind = dec_d ? K_DOUBLE_LIT : K_INT_LIT; end
          endcase
        end else begin
          cons = 1'b1;
          if (n_pc != 2'd2) begin
            pc_d = n_pc + 2'd1;
          end
          if (!n_stop) begin
            if (dv >= 7'(rv)) begin
              stop_d = 1'b1;
            end else begin
              acc_d = (prod[67:64] != 4'd0) ? '1 : prod[63:0];
            end
          end
        end
      end
    end

    if (num_emit) begin
      p_v = 1'b1; p_kind = num_kind; mode_d = M_IDLE;
      p_val = ((num_kind >= K_INT_LIT) && (num_kind <= K_ULONGLONG_LIT)) ? n_acc : '0;
    end

    if (!cons) begin
      sline_d = line_q; scol_d = col_q;
      if (is_digit(b)) begin
        mode_d = M_NUM; pc_d = 2'd1; dec_d = 1'b0; stop_d = 1'b0;
        rad_d = (b == "0") ? RADIX_OCT : RADIX_DEC;
        acc_d = {56'd0, b - "0"};
      end else if (is_alpha(b) || (b == "_")) begin
        mode_d = M_IDENT; cnt_d = 8'd1; wr_en = 1'b1; wr_idx = '0;
      end else begin
        case (b)
          8'h00: begin i_v = 1'b1; i_kind = K_END; end
          8'h0A, 8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: begin
          end
          ":": mode_d = M_COLON;
          ".": mode_d = M_DOT;
          "*": mode_d = M_STAR;
          "/": mode_d = M_SLASH;
          "%": mode_d = M_PCT;
          "+": mode_d = M_PLUS;
          "-": mode_d = M_MINUS;
          "<": mode_d = M_LT;
          ">": mode_d = M_GT;
          "=": mode_d = M_EQ;
          "!": mode_d = M_BANG;
          "&": mode_d = M_AMP;
          "^": mode_d = M_CARET;
          "|": mode_d = M_BAR;
          ",": begin i_v = 1'b1; i_kind = K_COMMA; end
          "~": begin i_v = 1'b1; i_kind = K_BNOT; end
          "(": begin i_v = 1'b1; i_kind = K_LPAREN; end
          ")": begin i_v = 1'b1; i_kind = K_RPAREN; end
          "[": begin i_v = 1'b1; i_kind = K_LSQ; end
          "]": begin i_v = 1'b1; i_kind = K_RSQ; end
          "{": begin i_v = 1'b1; i_kind = K_LCURLY; end
          "}": begin i_v = 1'b1; i_kind = K_RCURLY; end
          ";": begin i_v = 1'b1; i_kind = K_SEMI; end
          default: begin i_v = 1'b1; i_kind = K_UNKNOWN; end
        endcase
      end
    end

    if (b == 8'h00) begin
      mode_d = M_IDLE; line_d = 16'd1; col_d = 12'd1;
    end else if (b == 8'h0A) begin
      if (line_q != LINE_MAX) begin
        line_d = line_q + 16'd1;
      end
      col_d = 12'd1;
    end else if (col_q != COL_MAX) begin
      col_d = col_q + 12'd1;
    end
  end

  always_comb begin
    push_o.v0          = acc && p_v;
    push_o.tok0.kind   = p_kind;
    push_o.tok0.line   = sline_q;
    push_o.tok0.column = scol_q;
    push_o.tok0.value  = p_val;
    push_o.tok0.len    = p_len;
    push_o.tok0.last   = !i_v;
    push_o.v1          = acc && i_v;
    push_o.tok1.kind   = i_kind;
    push_o.tok1.line   = line_q;
    push_o.tok1.column = col_q;
    push_o.tok1.value  = '0;
    push_o.tok1.len    = '0;
    push_o.tok1.last   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pc_q    <= '0;
      dec_q   <= 1'b0;
      stop_q  <= 1'b0;
      rad_q   <= RADIX_DEC;
      cnt_q   <= '0;
      line_q  <= 16'd1;
      col_q   <= 12'd1;
      sline_q <= '0;
      scol_q  <= '0;
    end else if (acc) begin
      mode_q  <= mode_d;
      pc_q    <= pc_d;
      dec_q   <= dec_d;
      stop_q  <= stop_d;
      rad_q   <= rad_d;
      cnt_q   <= cnt_d;
      line_q  <= line_d;
      col_q   <= col_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      acc_q <= acc_d;
      if (wr_en) begin
        idbuf_q[wr_idx] <= b;
      end
    end
  end

endmodule

[src/cppl_queue.sv]
// Token queue between the lexer front end and the output stage: two pushes
// and one pop per cycle. Depends on cppl_pkg.
module cppl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cppl_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            room_o,
  output logic            head_valid_o,
  output cppl_pkg::tok_t  head_o
);
  import cppl_pkg::*;

  localparam int unsigned PtrW = $clog2(QDEPTH);
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  tok_t            mem_q [QDEPTH];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d, wp_second;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop          = pop_i && (cnt_q != '0);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rp_q];
  assign room_o       = cnt_q <= CntW'(QDEPTH - 2);
  assign wp_second    = push_i.v0 ? wp_q + PtrW'(1) : wp_q;

  always_comb begin
    wp_d  = wp_q + PtrW'(push_i.v0) + PtrW'(push_i.v1);
    rp_d  = rp_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.v0) + CntW'(push_i.v1) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wp_q] <= push_i.tok0;
    end
    if (push_i.v1) begin
      mem_q[wp_second] <= push_i.tok1;
    end
  end

endmodule

[src/cppl_back.sv]
// Output stage: registers one token from the queue and holds it until the
// receiver takes it. Depends on cppl_pkg and cppl_token_if.
module cppl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  cppl_pkg::tok_t head_i,
  output logic           pop_o,
  cppl_token_if.source   token_o
);
  import cppl_pkg::*;

  logic valid_q;
  tok_t tok_q;
  logic load;

  assign load  = !valid_q || token_o.ready;
  assign pop_o = load && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tok_q <= head_i;
    end
  end

  assign token_o.valid         = valid_q;
  assign token_o.token_kind    = tok_q.kind;
  assign token_o.token_line    = tok_q.line;
  assign token_o.token_column  = tok_q.column;
  assign token_o.lit_value     = tok_q.value;
  assign token_o.ident_length  = tok_q.len;
  assign token_o.last_of_run   = tok_q.last;

endmodule

[src/cppl_checker.sv]
// Port-level checks of the C++ token lexer and the bind that attaches them.
// Depends on cppl_pkg and cpp_token_lexer_unit.
module cppl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [6:0]  kind_i,
  input logic [15:0] line_i,
  input logic [7:0]  len_i,
  input logic        last_i
);
  import cppl_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Token withdrawn while stalled.");

  a_hold_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(kind_i) && $stable(line_i))
    else $error("Token changed while stalled.");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == 7'(K_END)) |-> last_i)
    else $error("End token is not the last of its byte.");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> line_i != 16'd0)
    else $error("Token line is zero.");

  a_len_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != 7'(K_IDENT)) |-> len_i == 8'd0)
    else $error("Length set on a token that is no identifier.");

endmodule

bind cpp_token_lexer_unit cppl_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (token_o.valid),
  .out_ready_i (token_o.ready),
  .kind_i      (token_o.token_kind),
  .line_i      (token_o.token_line),
  .len_i       (token_o.ident_length),
  .last_i      (token_o.last_of_run)
);

[verif/tb_cpp_token_lexer_unit.sv]
// Self-checking testbench of the C++ token lexer: streams text bytes, predicts
// the tokens each byte causes and compares them in order with the token channel.
// Depends on cppl_pkg, cppl_if and cpp_token_lexer_unit.
class token_scoreboard;
  cppl_pkg::tok_t pending_tokens[$];
  int errors = 0;

  function void note_token(cppl_pkg::tok_t t);
    pending_tokens.push_back(t);
  endfunction

  function void check_token(cppl_pkg::tok_t got);
    cppl_pkg::tok_t exp;
    if (pending_tokens.size() == 0) begin
      $display("%0t: unexpected token, expected none, actual %h", $realtime, got);
      errors++;
      return;
    end
    exp = pending_tokens.pop_front();
    if (exp.kind != got.kind) begin
      $display("%0t: kind expected %0d actual %0d", $realtime, exp.kind, got.kind);
      errors++;
    end
    if (exp.line != got.line) begin
      $display("%0t: line expected %0d actual %0d", $realtime, exp.line, got.line);
      errors++;
    end
    if (exp.column != got.column) begin
      $display("%0t: column expected %0d actual %0d", $realtime, exp.column, got.column);
      errors++;
    end
    if (exp.value != got.value) begin
      $display("%0t: value expected %h actual %h", $realtime, exp.value, got.value);
      errors++;
    end
    if (exp.len != got.len) begin
      $display("%0t: length expected %0d actual %0d", $realtime, exp.len, got.len);
      errors++;
    end
    if (exp.last != got.last) begin
      $display("%0t: last expected %0d actual %0d", $realtime, exp.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_cpp_token_lexer_unit;
  import cppl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    P_IDLE, P_COLON, P_DOT, P_STAR, P_SLASH, P_PCT, P_PLUS, P_MINUS, P_ARROW,
    P_LT, P_LT2, P_GT, P_GT2, P_EQ, P_BANG, P_AMP, P_CARET, P_BAR, P_IDENT,
    P_NUM, P_SUF_U, P_SUF_UL, P_SUF_L
  } lex_state_e;

  localparam logic [7:0] FLAG_DOT = 8'h01;
  localparam logic [7:0] FLAG_STOP = 8'h02;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  cppl_byte_if text_i ();
  cppl_token_if token_o ();

  cpp_token_lexer_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .text_i(text_i.sink), .token_o(token_o.source)
  );

  always #5 clk_i = ~clk_i;

  token_scoreboard board = new();

  lex_state_e lstate = P_IDLE;
  logic [15:0] num_chars = 0;
  logic [7:0] name_buf[KEYWORD_MAX_LEN];
  logic [7:0] name_len = 0;
  logic [63:0] num_value = 0;
  logic [7:0] num_flags = 0;
  logic [15:0] cur_line = 1;
  logic [11:0] cur_col = 1;
  logic [15:0] tok_line = 0;
  logic [11:0] tok_col = 0;
  tok_t step_toks[$];
  bit rx_stall_mode = 0;
  bit mid_drained = 0;

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit hexl_c(logic [7:0] c);
    return (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic [7:0] lower_c(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void add_token(kind_e k, logic [63:0] v, logic [7:0] n);
    tok_t t;
    t.kind = k;
    t.line = tok_line;
    t.column = tok_col;
    t.value = v;
    t.len = n;
    t.last = 1'b0;
    if (step_toks.size() < 3) step_toks.push_back(t);
  endfunction

  function automatic void close_number(kind_e k);
    add_token(k, (k >= K_INT_LIT && k <= K_ULONGLONG_LIT) ? num_value : 64'd0, 0);
    lstate = P_IDLE;
  endfunction

  function automatic void close_name();
    string words[31];
    kind_e kinds[31];
    bit hit;
    words = '{"char", "wchar_t", {"char16", "_t"}, {"char32", "_t"}, "bool", "int",
      "float", "double", "class", "struct", "union", "enum", "short", "long", "signed",
      "unsigned", "static", "constexpr", "typedef", "const", "typeid",
      {"const", "_cast"}, {"dynamic", "_cast"}, {"reinterpret", "_cast"},
      {"static", "_cast"}, "new", "delete", "throw", "true", "false", "nullptr"};
    kinds = '{K_CHAR, K_WCHAR, K_CHAR16, K_CHAR32, K_BOOL, K_INT, K_FLOAT, K_DOUBLE,
      K_CLASS, K_STRUCT, K_UNION, K_ENUM, K_SHORT, K_LONG, K_SIGNED, K_UNSIGNED,
      K_STATIC, K_CONSTEXPR, K_TYPEDEF, K_CONST, K_TYPEID, K_CONSTCAST,
      K_DYNAMICCAST, K_REINTERPRETCAST, K_STATICCAST, K_NEW, K_DELETE, K_THROW,
      K_BOOL_LIT, K_BOOL_LIT, K_PTR_LIT};
    lstate = P_IDLE;
    if (name_len <= KEYWORD_MAX_LEN) begin
      for (int k = 0; k < 31; k++) begin
        hit = words[k].len() == name_len;
        for (int i = 0; hit && i < name_len; i++)
          if (words[k][i] != name_buf[i]) hit = 0;
        if (hit) begin
          add_token(kinds[k], words[k] == "true", 0);
          return;
        end
      end
    end
    add_token(K_IDENT, 0, name_len);
  endfunction

  function automatic void push_name(logic [7:0] c);
    if (name_len < KEYWORD_MAX_LEN) name_buf[name_len] = c;
    if (name_len < 255) name_len++;
  endfunction

  function automatic void begin_number(logic [7:0] c);
    num_value = 0;
    num_chars = 1;
    lstate = P_NUM;
    if (c == ".") num_flags = FLAG_DOT | FLAG_STOP;
    else if (c == "0") num_flags = {4'd0, RADIX_OCT, 2'd0};
    else begin
      num_flags = {4'd0, RADIX_DEC, 2'd0};
      num_value = c - "0";
    end
  endfunction

  function automatic void grow_number(logic [7:0] c);
    logic [63:0] d, r;
    if (num_flags & FLAG_STOP) return;
    if (digit_c(c)) d = c - "0";
    else if (hexl_c(c)) d = lower_c(c) - "a" + 10;
    else d = 99;
    case (radix_e'(num_flags[3:2]))
      RADIX_DEC: r = 10;
      RADIX_OCT: r = 8;
      RADIX_HEX: r = 16;
      default: r = 2;
    endcase
    if (d >= r) begin
      num_flags |= FLAG_STOP;
      return;
    end
    if (num_value > ((64'hFFFF_FFFF_FFFF_FFFF - d) / r)) num_value = '1;
    else num_value = num_value * r + d;
  endfunction

  function automatic bit number_byte(logic [7:0] b);
    bit dot_seen;
    if (num_chars == 1 && (b == "x" || b == "b")) begin
      if (radix_e'(num_flags[3:2]) == RADIX_OCT)
        num_flags[3:2] = (b == "x") ? RADIX_HEX : RADIX_BIN;
      else num_flags |= FLAG_STOP;
      num_chars++;
      return 1;
    end
    if (b == ".") num_flags |= FLAG_DOT;
    dot_seen = num_flags[0];
    if (digit_c(b) || b == "." || (!dot_seen && hexl_c(b))) begin
      grow_number(b);
      if (num_chars < 16'hFFFF) num_chars++;
      return 1;
    end
    case (lower_c(b))
      "u": begin lstate = P_SUF_U; return 1; end
      "l": begin lstate = P_SUF_L; return 1; end
      "f": begin close_number(K_FLOAT_LIT); return 1; end
      "d": begin close_number(K_DOUBLE_LIT); return 1; end
      default: begin
        close_number(dot_seen ? K_DOUBLE_LIT : K_INT_LIT);
        return 0;
      end
    endcase
  endfunction

  function automatic bit op_pair(logic [7:0] b, logic [7:0] c1, kind_e k1,
                                 logic [7:0] c2, kind_e k2, kind_e base);
    lstate = P_IDLE;
    if (b == c1) begin add_token(k1, 0, 0); return 1; end
    if (c2 != 0 && b == c2) begin add_token(k2, 0, 0); return 1; end
    add_token(base, 0, 0);
    return 0;
  endfunction

  function automatic bit continue_lexeme(logic [7:0] b);
    bit ell;
    ell = b == "l" || b == "L";
    case (lstate)
      P_IDLE: return 0;
      P_COLON: return op_pair(b, ":", K_SCOPE_RES, 0, K_COLON, K_COLON);
      P_DOT: begin
        if (digit_c(b)) begin begin_number("."); return number_byte(b); end
        return op_pair(b, "*", K_PTR_TO_MEMB, 0, K_MEMB_SEL, K_MEMB_SEL);
      end
      P_STAR: return op_pair(b, "=", K_MUL_ASSIGN, 0, K_MUL, K_MUL);
      P_SLASH: return op_pair(b, "=", K_DIV_ASSIGN, 0, K_DIV, K_DIV);
      P_PCT: return op_pair(b, "=", K_MOD_ASSIGN, 0, K_MOD, K_MOD);
      P_PLUS: return op_pair(b, "=", K_ADD_ASSIGN, "+", K_INC, K_ADD);
      P_MINUS: begin
        if (b == ">") begin lstate = P_ARROW; return 1; end
        return op_pair(b, "=", K_SUB_ASSIGN, "-", K_DEC, K_SUB);
      end
      P_ARROW: return op_pair(b, "*", K_PTR_PTR_MEMB, 0, K_PTR_MEMB, K_PTR_MEMB);
      P_LT: begin
        if (b == "<") begin lstate = P_LT2; return 1; end
        return op_pair(b, "=", K_LTEQ, 0, K_LT, K_LT);
      end
      P_LT2: return op_pair(b, "=", K_SHL_ASSIGN, 0, K_SHL, K_SHL);
      P_GT: begin
        if (b == ">") begin lstate = P_GT2; return 1; end
        return op_pair(b, "=", K_GTEQ, 0, K_GT, K_GT);
      end
      P_GT2: return op_pair(b, "=", K_SHR_ASSIGN, 0, K_SHR, K_SHR);
      P_EQ: return op_pair(b, "=", K_EQ, 0, K_ASSIGN, K_ASSIGN);
      P_BANG: return op_pair(b, "=", K_NEQ, 0, K_LNOT, K_LNOT);
      P_AMP: return op_pair(b, "&", K_LAND, "=", K_AND_ASSIGN, K_BAND);
      P_CARET: return op_pair(b, "=", K_XOR_ASSIGN, 0, K_BXOR, K_BXOR);
      P_BAR: return op_pair(b, "|", K_LOR, "=", K_OR_ASSIGN, K_BOR);
      P_IDENT: begin
        if (alpha_c(b) || digit_c(b) || b == "_") begin push_name(b); return 1; end
        close_name();
        return 0;
      end
      P_NUM: return number_byte(b);
      P_SUF_U: begin
        if (ell) begin lstate = P_SUF_UL; return 1; end
        close_number(K_UINT_LIT);
        return 0;
      end
      P_SUF_UL: begin
        close_number(ell ? K_ULONGLONG_LIT : K_ULONG_LIT);
        return ell;
      end
      default: begin
        close_number(ell ? K_LONGLONG_LIT : (num_flags[0] ? K_LONGDOUBLE_LIT : K_LONG_LIT));
        return ell;
      end
    endcase
  endfunction

  function automatic void start_lexeme(logic [7:0] b);
    tok_line = cur_line;
    tok_col = cur_col;
    if (digit_c(b)) begin begin_number(b); return; end
    if (alpha_c(b) || b == "_") begin
      name_len = 0;
      push_name(b);
      lstate = P_IDENT;
      return;
    end
    case (b)
      8'd0: add_token(K_END, 0, 0);
      "\n", " ", "\t", 8'h0B, 8'h0C, "\r": ;
      ":": lstate = P_COLON;
      ".": lstate = P_DOT;
      "*": lstate = P_STAR;
      "/": lstate = P_SLASH;
      "%": lstate = P_PCT;
      "+": lstate = P_PLUS;
      "-": lstate = P_MINUS;
      "<": lstate = P_LT;
      ">": lstate = P_GT;
      "=": lstate = P_EQ;
      "!": lstate = P_BANG;
      "&": lstate = P_AMP;
      "^": lstate = P_CARET;
      "|": lstate = P_BAR;
      ",": add_token(K_COMMA, 0, 0);
      "~": add_token(K_BNOT, 0, 0);
      "(": add_token(K_LPAREN, 0, 0);
      ")": add_token(K_RPAREN, 0, 0);
      "[": add_token(K_LSQ, 0, 0);
      "]": add_token(K_RSQ, 0, 0);
      "{": add_token(K_LCURLY, 0, 0);
      "}": add_token(K_RCURLY, 0, 0);
      ";": add_token(K_SEMI, 0, 0);
      default: add_token(K_UNKNOWN, 0, 0);
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] b);
    step_toks.delete();
    if (!continue_lexeme(b)) start_lexeme(b);
    if (b == 0) begin
      lstate = P_IDLE;
      cur_line = 1;
      cur_col = 1;
    end else if (b == "\n") begin
      if (cur_line != 16'hFFFF) cur_line++;
      cur_col = 1;
    end else if (cur_col != 12'hFFF) begin
      cur_col++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) board.note_token(step_toks[i]);
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      text_i.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_i.valid <= 1'b1;
    text_i.text_byte <= b;
    @(negedge clk_i);
    while (!text_i.ready) @(negedge clk_i);
    @(posedge clk_i);
    predict_tokens(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    text_i.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  function automatic string random_fragment();
    string frags[24];
    string s;
    int n;
    frags = '{"int", "x_1", {"reinterpret", "_cast"}, "constexpr", "nullptr", "wchar_t",
      "true", "false", "0x1F", "0b101", "017", "089", "1.5f", "2.L", "7ull",
      "3uL", "9ll", "12lu", "18446744073709551616", "<<=", ">>=", "->*", ".*", "::"};
    case ($urandom_range(0, 3))
      0: s = frags[$urandom_range(0, 23)];
      1: begin
        n = $urandom_range(1, 20);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(97, 122)))};
      end
      2: begin
        n = $urandom_range(1, 22);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
      end
      default: begin
        s = "+-*/%<>=!&^|:.,~()[]{};";
        s = string'(s[$urandom_range(0, s.len() - 1)]);
      end
    endcase
    return s;
  endfunction

  initial begin
    text_i.valid = 1'b0;
    text_i.text_byte = 8'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_text("a:: :.* . + += ++ - -= -- -> ->* < <= << <<=");
    send_text(" > >= >> >>= == = != ! && &= & ^= ^ || |= | ,~()[]{};\n");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte("#");
    send_text({"true false nullptr reinterpret", "_cast abcdefghijklmnopq ",
               "0xffffffffffffffffff"});
    send_text(" 0b12 08 .5 1.5e 3ul 4LL 5u 6l 1.2l 7f 8d ");
    send_byte(8'd0);
    wait_drained();
    for (int n = 0; n < 210; ) begin
      string frag;
      logic [7:0] b;
      if ($urandom_range(0, 9) == 0) begin
        b = $urandom_range(0, 255);
        send_byte(b);
        n++;
      end else begin
        frag = random_fragment();
        send_text(frag);
        n += frag.len();
        b = ($urandom_range(0, 3) == 0) ? "\n" : " ";
        if ($urandom_range(0, 2) == 0) begin
          send_byte(b);
          n++;
        end
      end
      if (!mid_drained && n > 100) begin
        wait_drained();
        mid_drained = 1'b1;
      end
    end
    send_byte(8'd0);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending_tokens.size() == 0)
      $display("tb_cpp_token_lexer_unit: done, clean");
    else
      $display("tb_cpp_token_lexer_unit: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    tok_t got;
    if (rst_ni && token_o.valid && token_o.ready) begin
      got.kind = token_o.token_kind;
      got.line = token_o.token_line;
      got.column = token_o.token_column;
      got.value = token_o.lit_value;
      got.len = token_o.ident_length;
      got.last = token_o.last_of_run;
      board.check_token(got);
    end
    if ($urandom_range(0, 63) == 0) rx_stall_mode <= ~rx_stall_mode;
    token_o.ready <= rx_stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
  end

  initial begin
    #2ms;
    $display("tb_cpp_token_lexer_unit: done, errors");
    $finish;
  end
endmodule

[files.f]
src/cppl_pkg.sv
src/cppl_if.sv
src/cppl_front.sv
src/cppl_queue.sv
src/cppl_back.sv
src/cpp_token_lexer_unit.sv
src/cppl_checker.sv
verif/tb_cpp_token_lexer_unit.sv
